// ===== rtl/core/deq_pkg.sv =====
// Shared request, status and encoding definitions for the deque unit.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int unsigned REQ_WIDTH    = 3;
    localparam int unsigned STATUS_WIDTH = 2;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5,
        REQ_CLEAR      = 3'd6
    } req_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

// ===== rtl/core/deq_req_if.sv =====
// Request channel: valid/ready handshake carrying one deque request.
`timescale 1ns / 1ps

interface deq_req_if #(
    parameter int COORD_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::REQ_WIDTH-1:0]        req_type;
    logic signed [COORD_WIDTH-1:0]        elem_x;
    logic signed [COORD_WIDTH-1:0]        elem_y;

    modport source (output valid, output req_type, output elem_x, output elem_y,
                    input ready);
    modport sink   (input valid, input req_type, input elem_x, input elem_y,
                    output ready);
endinterface

// ===== rtl/core/deq_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one deque result.
`timescale 1ns / 1ps

interface deq_rsp_if #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 7
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_WIDTH-1:0]        out_x;
    logic signed [COORD_WIDTH-1:0]        out_y;
    logic [deq_pkg::STATUS_WIDTH-1:0]     status;
    logic                                 is_empty_now;
    logic [COUNT_WIDTH-1:0]               fill_count;

    modport source (output valid, output out_x, output out_y, output status,
                    output is_empty_now, output fill_count, input ready);
    modport sink   (input valid, input out_x, input out_y, input status,
                    input is_empty_now, input fill_count, output ready);
endinterface

// ===== rtl/core/double_ended_queue_unit.sv =====
// Top level of the deque unit: control plus element RAM.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake      Payload
//  req       in   valid/ready    req_type, elem_x, elem_y
//  rsp       out  valid/ready    out_x, out_y, status, is_empty_now, fill_count
//
//  Push, pop, clear and empty peeks load their result into the output register
//  at the same edge as the request transfer. A peek on a non-empty deque reads
//  the single-port element RAM, whose read data is registered, and loads the
//  result once the output register is free; no request is taken meanwhile.
//  A new request is taken while a result waits, as long as the output
//  register empties in that same cycle or is already empty.
//  Reset (rst_n low, asynchronous) clears head, count, state and the output
//  valid; the RAM is not cleared, since only pushed entries are ever read.
//
module double_ended_queue_unit #(
    parameter int DEPTH       = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    localparam int ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam int DATA_WIDTH  = 2 * COORD_WIDTH;

    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic [ADDR_WIDTH-1:0] mem_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    // Sequence requests and hold the head pointer, count and result.
    deq_ctrl #(
        .DEPTH       (DEPTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ADDR_WIDTH  (ADDR_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    // Hold the elements, packed as {x, y}, one per ring slot.
    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/core/deq_store.sv =====
// Element store: single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module deq_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Deque control: head pointer, count, request sequencing and result register.
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH       = 64,
    parameter int COORD_WIDTH = 16,
    parameter int ADDR_WIDTH  = 6,
    parameter int COUNT_WIDTH = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    deq_req_if.sink                  req,
    deq_rsp_if.source                rsp,
    output logic                     mem_wr_en,
    output logic                     mem_rd_en,
    output logic [ADDR_WIDTH-1:0]    mem_addr,
    output logic [2*COORD_WIDTH-1:0] mem_wr_data,
    input  logic [2*COORD_WIDTH-1:0] mem_rd_data
);

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);
    localparam logic [ADDR_WIDTH-1:0]  LAST_SLOT  = ADDR_WIDTH'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [ADDR_WIDTH-1:0]         head_reg, head_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [COORD_WIDTH-1:0] out_y_reg, out_y_next;
    deq_pkg::status_t              status_reg, status_next;
    logic                          empty_reg, empty_next;
    logic [COUNT_WIDTH-1:0]        fill_reg, fill_next;

    logic                          slot_free;
    logic                          accept;
    logic                          load_out;
    deq_pkg::status_t              res_status;
    logic signed [COORD_WIDTH-1:0] res_x;
    logic signed [COORD_WIDTH-1:0] res_y;

    function automatic logic [ADDR_WIDTH-1:0] ring_add(
        input logic [ADDR_WIDTH-1:0]  base,
        input logic [COUNT_WIDTH-1:0] offs
    );
        logic [COUNT_WIDTH:0] sum;
        sum = (COUNT_WIDTH+1)'(base) + (COUNT_WIDTH+1)'(offs);
        if (sum >= (COUNT_WIDTH+1)'(DEPTH))
        begin
            sum = sum - (COUNT_WIDTH+1)'(DEPTH);
        end
        return sum[ADDR_WIDTH-1:0];
    endfunction

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_addr    = head_reg;
        mem_wr_data = {req.elem_x, req.elem_y};
        load_out    = 1'b0;
        res_status  = deq_pkg::STATUS_OK;
        res_x       = '0;
        res_y       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (deq_pkg::req_t'(req.req_type))
                        deq_pkg::REQ_PUSH_FRONT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                head_next  = (head_reg == '0) ? LAST_SLOT
                                                              : head_reg - 1'b1;
                                mem_wr_en  = 1'b1;
                                mem_addr   = head_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::REQ_PUSH_BACK:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                mem_addr   = ring_add(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::REQ_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                head_next  = ring_add(head_reg, COUNT_WIDTH'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::REQ_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::REQ_PEEK_FRONT,
                        deq_pkg::REQ_PEEK_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Result comes back from the RAM next cycle.
                                load_out   = 1'b0;
                                mem_rd_en  = 1'b1;
                                mem_addr   = (req.req_type == deq_pkg::REQ_PEEK_FRONT)
                                           ? head_reg
                                           : ring_add(head_reg, count_reg - 1'b1);
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    res_x      = mem_rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
                    res_y      = mem_rd_data[COORD_WIDTH-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        status_next    = status_reg;
        empty_next     = empty_reg;
        fill_next      = fill_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_x_next     = res_x;
            out_y_next     = res_y;
            status_next    = res_status;
            empty_next     = (count_next == '0);
            fill_next      = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        fill_reg   <= fill_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_x        = out_x_reg;
    assign rsp.out_y        = out_y_reg;
    assign rsp.status       = status_reg;
    assign rsp.is_empty_now = empty_reg;
    assign rsp.fill_count   = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count exceeds capacity");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("RAM read and write in the same cycle");

    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !req.ready)
        else $error("request taken while a peek is outstanding");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == deq_pkg::REQ_PUSH_BACK)
                && (count_reg != FULL_COUNT))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance the count");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) && slot_free) |=> (out_valid_reg
            && (status_reg == deq_pkg::STATUS_OK)))
        else $error("peek result not loaded");

endmodule
